@@ rtl/sld_pkg.sv @@
// Package of shared types and constants for the sync, length and XOR deframer.
`default_nettype none

package sld_pkg;

	// Width of one link byte.
	localparam int BYTE_W = 8;

	// Default largest frame length and the reset value of the sync byte.
	localparam int MAX_LENGTH_DEF = 16;
	localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h80;

	// One completed frame waiting in a store bank.
	typedef struct packed {
		logic              bank;
		logic [BYTE_W-1:0] last_idx;
	} cmd_t;

	// Sequencer states of the frame drain.
	typedef enum logic [1:0] {
		BK_IDLE,
		BK_FETCH,
		BK_SHOW
	} back_state_t;

endpackage

`default_nettype wire

@@ rtl/sld_if.sv @@
// Stream interfaces of the deframer: received bytes in, frame bytes out.
`default_nettype none

interface sld_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_data;

	modport source (output valid, output rx_data, input ready);
	modport sink (input valid, input rx_data, output ready);
endinterface

interface sld_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_data;
	logic       frame_last;

	modport source (output valid, output frame_data, output frame_last, input ready);
	modport sink (input valid, input frame_data, input frame_last, output ready);
endinterface

`default_nettype wire

@@ rtl/sync_length_xor_deframer.sv @@
// Top level of the sync, length and XOR checksum byte deframer.
// The front end takes one received byte in every cycle in which it is ready; it
// hunts for the sync byte, checks the length and the XOR checksum, and writes the
// frame into one of two store banks. Ready drops only while both banks hold
// completed frames that have not yet been drained. For each frame byte the drain
// first reads the store, then requests output and holds the byte until it is
// taken, while the front end goes on receiving the next frame into the other
// bank. There is no clearing pass after reset.
`default_nettype none

module sync_length_xor_deframer #(
	parameter int MAX_LENGTH = sld_pkg::MAX_LENGTH_DEF,
	localparam int STORE_DEPTH = MAX_LENGTH + 2,
	localparam int AW = $clog2(2 * STORE_DEPTH)
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	sld_rx_if.sink          rx,
	sld_frame_if.source     frame
);

	import sld_pkg::*;

	cmd_t            push_cmd;
	cmd_t            head;
	logic            push;
	logic            pop;
	logic            full;
	logic            nonempty;
	logic            st_we;
	logic [AW-1:0]   st_waddr;
	logic [7:0]      st_wdata;
	logic            st_re;
	logic [AW-1:0]   st_raddr;
	logic [7:0]      st_rdata;

	// Sync hunt, length and checksum checks.
	sld_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.rx       (rx),
		.q_full   (full),
		.q_push   (push),
		.q_cmd    (push_cmd),
		.st_we    (st_we),
		.st_waddr (st_waddr),
		.st_wdata (st_wdata)
	);

	// Completed frames waiting to be drained.
	sld_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.full    (full),
		.nonempty(nonempty),
		.head    (head)
	);

	// Two banks of frame store.
	sld_ram #(.WIDTH(BYTE_W), .DEPTH(2 * STORE_DEPTH)) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// Frame drain to the output channel.
	sld_back #(.MAX_LENGTH(MAX_LENGTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_nonempty(nonempty),
		.q_head    (head),
		.q_pop     (pop),
		.st_re     (st_re),
		.st_raddr  (st_raddr),
		.st_rdata  (st_rdata),
		.frame     (frame)
	);

endmodule

`default_nettype wire

@@ rtl/sld_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module sld_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 36,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port; read data holds between reads.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

@@ rtl/sld_front.sv @@
// Front end: sync hunt, length check, checksum and storing of frame bytes.
`default_nettype none

module sld_front #(
	parameter int MAX_LENGTH = sld_pkg::MAX_LENGTH_DEF,
	localparam int STORE_DEPTH = MAX_LENGTH + 2,
	localparam int AW = $clog2(2 * STORE_DEPTH),
	localparam int IDX_W = $clog2(STORE_DEPTH),
	localparam int LEN_W = $clog2(MAX_LENGTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [7:0]    cfg_wdata,
	sld_rx_if.sink             rx,
	input  wire logic          q_full,
	output logic               q_push,
	output sld_pkg::cmd_t      q_cmd,
	output logic               st_we,
	output logic [AW-1:0]      st_waddr,
	output logic [7:0]         st_wdata
);

	import sld_pkg::*;

	logic [BYTE_W-1:0] sync_q;
	logic              in_sync_q;
	logic [IDX_W-1:0]  held_q;
	logic [LEN_W-1:0]  len_q;
	logic [BYTE_W-1:0] xor_q;
	logic              bank_q;

	logic              accept;
	logic              take;
	logic [BYTE_W-1:0] b;
	logic [IDX_W-1:0]  pos;
	logic [IDX_W-1:0]  lim;
	logic              len_bad;
	logic              is_check;

	// A byte is taken only while a store bank is free.
	assign rx.ready = !q_full;
	assign accept   = rx.valid && rx.ready;
	assign b        = rx.rx_data;

	// A matching byte while hunting starts a frame at position zero.
	assign take     = accept && (in_sync_q || (b == sync_q));
	assign pos      = in_sync_q ? held_q : '0;
	assign lim      = IDX_W'(len_q) + IDX_W'(1);
	assign len_bad  = (b == '0) || (b > BYTE_W'(MAX_LENGTH));
	assign is_check = (pos >= IDX_W'(2)) && (pos >= lim);

	// Store write: every byte of a frame goes to its place in the current bank.
	assign st_we    = take;
	assign st_waddr = bank_q ? (AW'(pos) + AW'(STORE_DEPTH)) : AW'(pos);
	assign st_wdata = b;

	// A good checksum hands the bank over to the drain.
	assign q_push        = take && is_check && (b == xor_q);
	assign q_cmd.bank     = bank_q;
	assign q_cmd.last_idx = BYTE_W'(lim);

	// Sync byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	// Frame tracking state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sync_q <= 1'b0;
			held_q    <= '0;
			len_q     <= '0;
			xor_q     <= '0;
			bank_q    <= 1'b0;
		end else if (take) begin
			if (pos == '0) begin
				in_sync_q <= 1'b1;
				held_q    <= IDX_W'(1);
				xor_q     <= b;
			end else if (pos == IDX_W'(1)) begin
				if (len_bad) begin
					in_sync_q <= 1'b0;
					held_q    <= '0;
					len_q     <= '0;
					xor_q     <= '0;
				end else begin
					held_q <= IDX_W'(2);
					len_q  <= LEN_W'(b);
					xor_q  <= xor_q ^ b;
				end
			end else if (!is_check) begin
				held_q <= held_q + IDX_W'(1);
				xor_q  <= xor_q ^ b;
			end else begin
				// Checksum byte: keep sync only on a match.
				in_sync_q <= (b == xor_q);
				held_q    <= '0;
				len_q     <= '0;
				xor_q     <= '0;
				if (b == xor_q) begin
					bank_q <= !bank_q;
				end
			end
		end
	end

	// A completed frame never goes to a full queue.
	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("frame completed with both banks busy");

	// Each completed frame moves writing to the other bank.
	a_bank_flip: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> (bank_q != $past(bank_q)))
		else $error("bank not switched after a completed frame");

	// While hunting no frame bytes are counted.
	a_hunt_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_sync_q |-> (held_q == '0) && (xor_q == '0))
		else $error("frame state left over while hunting");

endmodule

`default_nettype wire

@@ rtl/sld_cmd_q.sv @@
// Two-entry queue of completed frames between the front end and the drain.
`default_nettype none

module sld_cmd_q (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sld_pkg::cmd_t  push_cmd,
	input  wire logic           pop,
	output logic                full,
	output logic                nonempty,
	output sld_pkg::cmd_t       head
);

	import sld_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'd2);
	assign nonempty = (count_q != 2'd0);
	assign head     = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into a full frame queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from an empty frame queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != 2'd3) && ((wr_ptr_q != rd_ptr_q) == (count_q == 2'd1)))
		else $error("frame queue pointers and count disagree");

endmodule

`default_nettype wire

@@ rtl/sld_back.sv @@
// Drain: reads a completed frame out of its store bank one byte at a time.
`default_nettype none

module sld_back #(
	parameter int MAX_LENGTH = sld_pkg::MAX_LENGTH_DEF,
	localparam int STORE_DEPTH = MAX_LENGTH + 2,
	localparam int AW = $clog2(2 * STORE_DEPTH),
	localparam int IDX_W = $clog2(STORE_DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_nonempty,
	input  wire sld_pkg::cmd_t q_head,
	output logic               q_pop,
	output logic               st_re,
	output logic [AW-1:0]      st_raddr,
	input  wire logic [7:0]    st_rdata,
	sld_frame_if.source        frame
);

	import sld_pkg::*;

	back_state_t      state_q;
	back_state_t      state_d;
	logic [IDX_W-1:0] idx_q;
	logic             is_last;
	logic             done;

	assign is_last  = (idx_q == IDX_W'(q_head.last_idx));
	assign done     = (state_q == BK_SHOW) && frame.ready && is_last;
	assign st_raddr = q_head.bank ? (AW'(idx_q) + AW'(STORE_DEPTH)) : AW'(idx_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (q_nonempty) begin
					state_d = BK_FETCH;
				end
			end
			BK_FETCH: begin
				state_d = BK_SHOW;
			end
			BK_SHOW: begin
				if (frame.ready) begin
					state_d = is_last ? BK_IDLE : BK_FETCH;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		st_re            = 1'b0;
		frame.valid      = 1'b0;
		q_pop            = 1'b0;
		case (state_q)
			BK_FETCH: begin
				st_re = 1'b1;
			end
			BK_SHOW: begin
				frame.valid = 1'b1;
				q_pop       = frame.ready && is_last;
			end
			default: begin
				st_re = 1'b0;
			end
		endcase
	end

	assign frame.frame_data = st_rdata;
	assign frame.frame_last = is_last;

	// State and byte index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_IDLE) begin
				idx_q <= '0;
			end else if ((state_q == BK_SHOW) && frame.ready) begin
				idx_q <= is_last ? '0 : (idx_q + IDX_W'(1));
			end
		end
	end

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (frame.valid && frame.ready && frame.frame_last))
		else $error("frame released before its last byte was taken");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (state_q == BK_IDLE) && (idx_q == '0))
		else $error("drain did not return to idle after the last byte");

	// A shown byte was read just before, or is still waiting to be taken.
	a_read_before_show: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SHOW) |-> ($past(st_re) || $past(state_q == BK_SHOW)))
		else $error("byte shown without a store read");

endmodule

`default_nettype wire
